// File: design/mau_pkg.sv
// Shared types and constants for the modular arithmetic unit.
// No dependencies.
`default_nettype none
package mau_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 30;
   localparam longint unsigned MODULUS_RESET = 64'd1000000007;
   localparam int DIV_DIVIDEND_WIDTH = 64;
   localparam int DIV_COUNT_WIDTH = $clog2(DIV_DIVIDEND_WIDTH);

   localparam logic [2:0] ACT_ADD = 3'd0;
   localparam logic [2:0] ACT_SUB = 3'd1;
   localparam logic [2:0] ACT_MUL = 3'd2;
   localparam logic [2:0] ACT_DIV = 3'd3;
   localparam logic [2:0] ACT_INV = 3'd4;
   localparam logic [2:0] ACT_POW = 3'd5;
   localparam logic [2:0] ACT_RED = 3'd6;
   // unused code, answers 0
   localparam logic [2:0] ACT_UNUSED = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_DISPATCH,
      ST_INV_TEST,
      ST_INV_DIV,
      ST_INV_UPD,
      ST_SRED,
      ST_MUL,
      ST_PROD,
      ST_POW_TEST,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

// File: design/mau_divider.sv
// Restoring bit-serial divider: 64-bit dividend by a VALUE_WIDTH divisor.
// One quotient bit per cycle. Depends on mau_pkg.
`default_nettype none
module mau_divider #(
   parameter int VALUE_WIDTH = mau_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      start,
   input  wire logic [mau_pkg::DIV_DIVIDEND_WIDTH-1:0]    dividend,
   input  wire logic [VALUE_WIDTH-1:0]                    divisor,
   output logic                                           done,
   output logic [mau_pkg::DIV_DIVIDEND_WIDTH-1:0]         quotient,
   output logic [VALUE_WIDTH-1:0]                         remainder
);
   import mau_pkg::*;

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [DIV_COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [DIV_DIVIDEND_WIDTH-1:0]  num_ff, num_in;
   logic [VALUE_WIDTH-1:0]         rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0]         dsr_ff, dsr_in;
   logic [VALUE_WIDTH:0]           trial;
   logic [VALUE_WIDTH:0]           diff;
   logic                           fits;

   assign trial = {rem_ff, num_ff[DIV_DIVIDEND_WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (busy_ff) begin
         num_in   = {num_ff[DIV_DIVIDEND_WIDTH-2:0], fits};
         rem_in   = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_COUNT_WIDTH'(DIV_DIVIDEND_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         num_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// File: design/mau_multiplier.sv
// Registered signed multiplier shared by products, powers and Euclid updates.
// Depends on mau_pkg for the default width.
`default_nettype none
module mau_multiplier #(
   parameter int VALUE_WIDTH = mau_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic signed [VALUE_WIDTH+1:0]      mul_x,
   input  wire logic signed [VALUE_WIDTH+1:0]      mul_y,
   output logic signed [2*VALUE_WIDTH+3:0]         product
);
   import mau_pkg::*;

   logic signed [2*VALUE_WIDTH+3:0] prod_ff, prod_in;

   assign prod_in = mul_x * mul_y;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule
`default_nettype wire

// File: design/modular_arithmetic_unit.sv
// Modular arithmetic unit: add, sub, mul, div, inverse, power, signed reduce.
// One word in on the req_ channel, one word out on the rsp_ channel.
// The modulus register is written through csr_write_enable/csr_write_data
// and resets to 1000000007; write it only while the unit is idle.
// A word is taken when req_valid is high and req_stall low. req_stall stays
// high from then until the result is taken on the rsp_ channel, so one word
// is in flight at a time; the next word can be taken in the cycle after that.
// rsp_result holds while rsp_stall is high. Modulus zero returns 0 in the
// cycle after the word is taken. Reset returns to idle.
// Each reduction runs on the serial divider, each product on the registered multiplier:
//   add, sub:       two operand reductions
//   mul:            operand reductions, then a product and its reduction
//   reduce signed:  operand reductions, then the signed value's reduction
//   inverse, div:   operand reductions, a division and an update per Euclid step
//                   (up to ~45 steps), the final reduction, for div a product and reduction
//   power:          operand reductions, then per exponent bit a squaring, per
//                   set bit a product, each with its reduction
`default_nettype none
module modular_arithmetic_unit #(
   parameter int VALUE_WIDTH = mau_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [2:0]               req_action,
   input  wire logic [VALUE_WIDTH-1:0]   req_operand_a,
   input  wire logic [VALUE_WIDTH-1:0]   req_operand_b,
   input  wire logic [62:0]              req_exponent,
   input  wire logic signed [63:0]       req_signed_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [VALUE_WIDTH-1:0]        rsp_result,
   input  wire logic                     csr_write_enable,
   input  wire logic [VALUE_WIDTH-1:0]   csr_write_data
);
   import mau_pkg::*;

   localparam int PW = 2 * VALUE_WIDTH + 4;

   state_type state_ff, state_in;
   logic [VALUE_WIDTH-1:0]        m_ff;
   logic [2:0]                    act_ff, act_in;
   logic [VALUE_WIDTH-1:0]        a_ff, a_in, b_ff, b_in;
   logic [62:0]                   e_ff, e_in;
   logic [63:0]                   sv_ff, sv_in;
   logic [VALUE_WIDTH-1:0]        x_ff, x_in, y_ff, y_in;
   logic signed [VALUE_WIDTH+1:0] u_ff, u_in, v_ff, v_in;
   logic [VALUE_WIDTH-1:0]        acc_ff, acc_in, sq_ff, sq_in, res_ff, res_in;
   logic                          neg_ff, neg_in, pow_sq_ff, pow_sq_in;

   logic                          div_start, div_done;
   logic [DIV_DIVIDEND_WIDTH-1:0] div_dividend, div_quot;
   logic [VALUE_WIDTH-1:0]        div_divisor, div_rem;
   logic signed [VALUE_WIDTH+1:0] mul_x, mul_y;
   logic signed [PW-1:0]          mul_prod;

   logic [VALUE_WIDTH:0]          sum_add, sum_sub;
   logic [63:0]                   val64, mag64;
   logic [VALUE_WIDTH-1:0]        sred_val;
   logic signed [PW-1:0]          nu_wide;
   logic                          req_take;

   mau_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   mau_multiplier #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul (
      .clock   (clock),
      .mul_x   (mul_x),
      .mul_y   (mul_y),
      .product (mul_prod)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_result = res_ff;

   assign sum_add = {1'b0, a_ff} + {1'b0, b_ff};
   assign sum_sub = {1'b0, a_ff} + {1'b0, m_ff} - {1'b0, b_ff};
   // signed source for reduce: the Euclid coefficient or the input value
   assign val64   = (state_ff == ST_INV_TEST) ? 64'(u_ff) : sv_ff;
   assign mag64   = val64[63] ? (64'd0 - val64) : val64;
   assign sred_val = (neg_ff && (div_rem != '0)) ? (m_ff - div_rem) : div_rem;
   assign nu_wide = PW'(u_ff) - mul_prod;

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      e_in         = e_ff;
      sv_in        = sv_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      res_in       = res_ff;
      neg_in       = neg_ff;
      pow_sq_in    = pow_sq_ff;
      div_start    = 1'b0;
      div_dividend = 64'(req_operand_a);
      div_divisor  = m_ff;
      mul_x        = $signed({2'b00, a_ff});
      mul_y        = $signed({2'b00, b_ff});

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               act_in = req_action;
               b_in   = req_operand_b;
               e_in   = req_exponent;
               sv_in  = req_signed_value;
               if (m_ff == '0) begin
                  res_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_RED_A;
               end
            end
         end
         ST_RED_A: begin
            if (div_done) begin
               a_in         = div_rem;
               div_start    = 1'b1;
               div_dividend = 64'(b_ff);
               state_in     = ST_RED_B;
            end
         end
         ST_RED_B: begin
            if (div_done) begin
               b_in     = div_rem;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (act_ff) inside
               ACT_ADD: begin
                  res_in = (sum_add >= {1'b0, m_ff}) ?
                           VALUE_WIDTH'(sum_add - {1'b0, m_ff}) :
                           sum_add[VALUE_WIDTH-1:0];
                  state_in = ST_OUT;
               end
               ACT_SUB: begin
                  res_in = (sum_sub >= {1'b0, m_ff}) ?
                           VALUE_WIDTH'(sum_sub - {1'b0, m_ff}) :
                           sum_sub[VALUE_WIDTH-1:0];
                  state_in = ST_OUT;
               end
               ACT_MUL: begin
                  state_in = ST_MUL;
               end
               ACT_DIV, ACT_INV: begin
                  x_in     = (act_ff == ACT_DIV) ? b_ff : a_ff;
                  y_in     = m_ff;
                  u_in     = (VALUE_WIDTH+2)'(1);
                  v_in     = '0;
                  state_in = ST_INV_TEST;
               end
               ACT_POW: begin
                  acc_in   = (m_ff == VALUE_WIDTH'(1)) ? '0 : VALUE_WIDTH'(1);
                  sq_in    = a_ff;
                  state_in = ST_POW_TEST;
               end
               ACT_RED: begin
                  neg_in       = val64[63];
                  div_start    = 1'b1;
                  div_dividend = mag64;
                  state_in     = ST_SRED;
               end
               default: begin
                  res_in   = '0;
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_INV_TEST: begin
            div_start = 1'b1;
            if (y_ff == '0) begin
               // Euclid done: bring the coefficient into range
               neg_in       = val64[63];
               div_dividend = mag64;
               state_in     = ST_SRED;
            end else begin
               div_dividend = 64'(x_ff);
               div_divisor  = y_ff;
               state_in     = ST_INV_DIV;
            end
         end
         ST_INV_DIV: begin
            mul_x = $signed({2'b00, div_quot[VALUE_WIDTH-1:0]});
            mul_y = v_ff;
            if (div_done) begin
               state_in = ST_INV_UPD;
            end
         end
         ST_INV_UPD: begin
            x_in     = y_ff;
            y_in     = div_rem;
            u_in     = v_ff;
            v_in     = nu_wide[VALUE_WIDTH+1:0];
            state_in = ST_INV_TEST;
         end
         ST_SRED: begin
            mul_y = $signed({2'b00, sred_val});
            if (div_done) begin
               res_in   = sred_val;
               state_in = (act_ff == ACT_DIV) ? ST_MUL : ST_OUT;
            end
         end
         ST_MUL: begin
            // product registered last cycle; reduce it
            div_start    = 1'b1;
            div_dividend = 64'(mul_prod);
            state_in     = ST_PROD;
         end
         ST_PROD: begin
            mul_x = $signed({2'b00, div_rem});
            mul_y = $signed({2'b00, div_rem});
            if (div_done) begin
               if (act_ff == ACT_POW) begin
                  if (pow_sq_ff) begin
                     sq_in    = div_rem;
                     e_in     = e_ff >> 1;
                     state_in = ST_POW_TEST;
                  end else begin
                     acc_in    = div_rem;
                     mul_x     = $signed({2'b00, sq_ff});
                     mul_y     = $signed({2'b00, sq_ff});
                     pow_sq_in = 1'b1;
                     state_in  = ST_MUL;
                  end
               end else begin
                  res_in   = div_rem;
                  state_in = ST_OUT;
               end
            end
         end
         ST_POW_TEST: begin
            if (e_ff == '0) begin
               res_in   = acc_ff;
               state_in = ST_OUT;
            end else if (e_ff[0]) begin
               mul_x     = $signed({2'b00, acc_ff});
               mul_y     = $signed({2'b00, sq_ff});
               pow_sq_in = 1'b0;
               state_in  = ST_MUL;
            end else begin
               mul_x     = $signed({2'b00, sq_ff});
               mul_y     = $signed({2'b00, sq_ff});
               pow_sq_in = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         m_ff     <= VALUE_WIDTH'(MODULUS_RESET);
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            m_ff <= csr_write_data;
         end
      end
      act_ff    <= act_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      e_ff      <= e_in;
      sv_ff     <= sv_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      acc_ff    <= acc_in;
      sq_ff     <= sq_in;
      res_ff    <= res_in;
      neg_ff    <= neg_in;
      pow_sq_ff <= pow_sq_in;
   end

endmodule
`default_nettype wire

// File: test/tb_modular_arithmetic_unit.sv
// Self-checking testbench for modular_arithmetic_unit: a directed table, then random words,
// over several moduli. Each result is checked against a table value or an arithmetic model.
// Depends on design/mau_pkg.sv and design/modular_arithmetic_unit.sv.
`timescale 1ns / 100ps
module tb_modular_arithmetic_unit;
   import mau_pkg::*;

   localparam int VW = VALUE_WIDTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 60000;

   typedef struct {
      logic [2:0]        action;
      logic [VW-1:0]     a;
      logic [VW-1:0]     b;
      logic [62:0]       e;
      logic [63:0]       sv;
      bit                known;
      logic [VW-1:0]     result;
   } vector_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0] req_action = '0;
   logic [VW-1:0] req_operand_a = '0;
   logic [VW-1:0] req_operand_b = '0;
   logic [62:0] req_exponent = '0;
   logic signed [63:0] req_signed_value = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [VW-1:0] rsp_result;
   logic csr_write_enable = 0;
   logic [VW-1:0] csr_write_data = '0;

   logic [VW-1:0] pending_results[$];
   longint unsigned cur_mod = MODULUS_RESET;
   int error_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit accepted_now;
   vector_type dir_tab[16];

   modular_arithmetic_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .req_exponent(req_exponent), .req_signed_value(req_signed_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result(rsp_result),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned fold_signed(longint unsigned raw, longint unsigned m);
      longint unsigned mag;
      if (!raw[63]) return raw % m;
      mag = 64'd0 - raw;
      return (m - (mag % m)) % m;
   endfunction

   function automatic longint unsigned euclid_inverse(longint unsigned a, longint unsigned m);
      longint x, y, u, v, q, nx, nu;
      x = a; y = m; u = 1; v = 0;
      while (y > 0) begin
         q = x / y;
         nx = x - q * y;
         nu = u - q * v;
         x = y; y = nx; u = v; v = nu;
      end
      return fold_signed(u, m);
   endfunction

   function automatic logic [VW-1:0] modular_result(vector_type w, longint unsigned m);
      longint unsigned a, b, e, acc, sq, r;
      if (m == 0) return '0;
      a = w.a % m;
      b = w.b % m;
      e = w.e;
      r = 0;
      case (w.action)
         ACT_ADD: r = (a + b) % m;
         ACT_SUB: r = (a + m - b) % m;
         ACT_MUL: r = (a * b) % m;
         ACT_DIV: r = (a * euclid_inverse(b, m)) % m;
         ACT_INV: r = euclid_inverse(a, m);
         ACT_POW: begin
            acc = 1 % m;
            sq = a;
            while (e > 0) begin
               if (e[0]) acc = (acc * sq) % m;
               sq = (sq * sq) % m;
               e = e >> 1;
            end
            r = acc;
         end
         ACT_RED: r = fold_signed(w.sv, m);
         default: r = 0;
      endcase
      return r[VW-1:0];
   endfunction

   // accept a word; valid stays high if the caller sends again with no gap
   task automatic send_word(vector_type w);
      req_action <= w.action;
      req_operand_a <= w.a;
      req_operand_b <= w.b;
      req_exponent <= w.e;
      req_signed_value <= w.sv;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (w.known) pending_results.push_back(w.result);
      else pending_results.push_back(modular_result(w, cur_mod));
      words_sent++;
   endtask

   task automatic sender_gap();
      int g;
      g = ($urandom_range(0, 3) == 0) ? 0 : ($urandom_range(0, 19) == 0 ?
          $urandom_range(20, 60) : $urandom_range(0, 3));
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain_and_set_modulus(logic [VW-1:0] m);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_mod = m;
      @(posedge clock);
   endtask

   function automatic vector_type random_word(longint unsigned m);
      vector_type w;
      w.action = ($urandom_range(0, 15) == 0) ? ACT_UNUSED : 3'($urandom_range(0, 6));
      w.a = VW'($urandom);
      w.b = VW'($urandom);
      if (m > 1 && $urandom_range(0, 1)) begin
         w.a = VW'(w.a % m);
         w.b = VW'(w.b % m);
      end
      // keep most exponents short; the full width is slow
      if ($urandom_range(0, 19) == 0) w.e = 63'({$urandom, $urandom});
      else w.e = 63'($urandom_range(0, 16'hffff));
      w.sv = {$urandom, $urandom};
      w.known = 0;
      w.result = '0;
      return w;
   endfunction

   // response side: random stall, mostly short, now and then a long one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 99) < 8) begin
         rsp_stall <= 1'b1;
         if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(20, 80);
      end else if ($urandom_range(0, 99) < 40) begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      accepted_now = 0;
      if (!reset && req_valid && !req_stall) accepted_now = 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         accepted_now = 1;
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected: result actual %0d", rsp_result);
            error_count++;
         end else begin
            if (rsp_result !== pending_results[0]) begin
               $error("result mismatch: expected %0d actual %0d", pending_results[0], rsp_result);
               error_count++;
            end
            void'(pending_results.pop_front());
            words_checked++;
         end
      end
      idle_cycles = accepted_now ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_modular_arithmetic_unit: done, errors");
         $finish;
      end
   end

   initial begin
      logic [VW-1:0] moduli[10];
      longint unsigned m0;
      int n;
      m0 = MODULUS_RESET;
      dir_tab = '{
         '{ACT_ADD, 0, 0, 0, 0, 1, 0},
         '{ACT_ADD, VW'(m0 - 1), 1, 0, 0, 1, 0},
         '{ACT_SUB, 0, 1, 0, 0, 1, VW'(m0 - 1)},
         '{ACT_MUL, VW'(m0 - 1), VW'(m0 - 1), 0, 0, 1, 1},
         '{ACT_DIV, 12345, 0, 0, 0, 1, 0},
         '{ACT_DIV, 7, 3, 0, 0, 0, 0},
         '{ACT_INV, 0, 0, 0, 0, 1, 0},
         '{ACT_INV, 1, 0, 0, 0, 1, 1},
         '{ACT_INV, VW'(m0 - 1), 0, 0, 0, 1, VW'(m0 - 1)},
         '{ACT_POW, 5, 0, 0, 0, 1, 1},
         '{ACT_POW, {VW{1'b1}}, {VW{1'b1}}, {63{1'b1}}, 0, 0, 0},
         '{ACT_RED, 0, 0, 0, -64'sd1, 1, VW'(m0 - 1)},
         '{ACT_RED, 0, 0, 0, {1'b1, 63'd0}, 0, 0},
         '{ACT_RED, 0, 0, 0, {1'b0, {63{1'b1}}}, 0, 0},
         '{ACT_UNUSED, {VW{1'b1}}, {VW{1'b1}}, {63{1'b1}}, {64{1'b1}}, 1, 0},
         '{ACT_MUL, {VW{1'b1}}, {VW{1'b1}}, 0, 0, 0, 0}
      };
      moduli = '{VW'(m0), 30'd998244353, 30'd2, 30'd3, {VW{1'b1}}, 30'd0, 30'd1,
                 30'd65537, 30'd7, VW'(m0)};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_tab[i]) begin
         send_word(dir_tab[i]);
         sender_gap();
      end
      foreach (moduli[p]) begin
         drain_and_set_modulus(moduli[p]);
         n = (moduli[p] < 2) ? 60 : 220;
         repeat (n) begin
            send_word(random_word(cur_mod));
            sender_gap();
         end
      end
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d words over ten modulus settings (zero, one, two, max, primes)",
               words_sent);
      $display("all seven operations plus the unused code; %0d results checked", words_checked);
      if (error_count == 0 && pending_results.size() == 0)
         $display("tb_modular_arithmetic_unit: done, clean");
      else
         $display("tb_modular_arithmetic_unit: done, errors");
      $finish;
   end
endmodule

// File: files.f
design/mau_pkg.sv
design/mau_divider.sv
design/mau_multiplier.sv
design/modular_arithmetic_unit.sv
test/tb_modular_arithmetic_unit.sv
